FILE: src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; the controller, datapath and top level import this package.
package ffha_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned STORE_AW = 16;
  localparam int unsigned HDR_W = 32;
  localparam int unsigned SIZE_W = 31;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned REQ_W = 32;
  localparam int unsigned OFS_W = 32;

  localparam logic [OFS_W-1:0] HEAP_BYTES = 32'd65536;
  localparam logic [OFS_W-1:0] HEADER_BYTES = 32'd4;

  localparam logic OP_FREE = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FREE_WR,
    ST_SEARCH,
    ST_MERGE,
    ST_DECIDE,
    ST_SPLIT,
    ST_DONE
  } ffha_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_INIT_WR,
    DP_LOAD,
    DP_FREE_WR,
    DP_SRCH_STEP,
    DP_SRCH_HIT,
    DP_MERGE_STEP,
    DP_MERGE_END,
    DP_TAKE_SPLIT,
    DP_TAKE_WHOLE,
    DP_ADV,
    DP_SPLIT_WR
  } ffha_dp_op_t;

  typedef struct packed {
    ffha_dp_op_t op;
    logic        out_load;
  } ffha_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_big;
    logic p_past_end;
    logic hdr_free;
    logic hdr_size_zero;
    logic merge_go;
    logic fits;
    logic rest_big;
    logic size_zero;
    logic out_stall;
  } ffha_sts_t;

endpackage

FILE: src/ffha_in_if.sv
// Request channel of the heap allocator: valid/ready handshake and payload.
// No dependencies.
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] request_size;
  logic [15:0] block_address;

  modport source (output valid, operation, request_size, block_address, input ready);
  modport sink (input valid, operation, request_size, block_address, output ready);
endinterface

FILE: src/ffha_out_if.sv
// Result channel of the heap allocator: valid/ready handshake and payload.
// No dependencies.
interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [15:0] result_address;

  modport source (output valid, success, result_address, input ready);
  modport sink (input valid, success, result_address, output ready);
endinterface

FILE: src/ffha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ffha_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

FILE: src/ffha_ctrl.sv
// Controller state machine of the heap allocator.
// Depends on ffha_pkg; drives datapath commands and reads datapath status.
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffha_pkg::ffha_sts_t sts,
  output ffha_pkg::ffha_cmd_t cmd
);
  import ffha_pkg::*;

  ffha_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '{op: DP_NOP, out_load: 1'b0};
    unique case (state_r)
      ST_INIT: begin
        cmd.op = DP_INIT_WR;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          priority if (sts.is_free) begin
            state_nxt = ST_FREE_WR;
          end else if (sts.too_big) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_FREE_WR: begin
        cmd.op = DP_FREE_WR;
        state_nxt = ST_DONE;
      end
      ST_SEARCH: begin
        priority if (sts.p_past_end) begin
          state_nxt = ST_DONE;
        end else if (!sts.hdr_free && sts.hdr_size_zero) begin
          state_nxt = ST_DONE;
        end else if (!sts.hdr_free) begin
          cmd.op = DP_SRCH_STEP;
        end else begin
          cmd.op = DP_SRCH_HIT;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (sts.merge_go) begin
          cmd.op = DP_MERGE_STEP;
        end else begin
          cmd.op = DP_MERGE_END;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (sts.fits && sts.rest_big) begin
          cmd.op = DP_TAKE_SPLIT;
          state_nxt = ST_SPLIT;
        end else if (sts.fits) begin
          cmd.op = DP_TAKE_WHOLE;
          state_nxt = ST_DONE;
        end else if (sts.size_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op = DP_ADV;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SPLIT: begin
        cmd.op = DP_SPLIT_WR;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start work");

  a_split_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |-> ($past(state_r) == ST_DECIDE))
    else $error("split entered without a fitting chunk");

  a_merge_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE && !sts.merge_go) |=> (state_r == ST_DECIDE))
    else $error("merge did not hand over to decide");

  a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !sts.out_stall) |=> (state_r == ST_IDLE))
    else $error("result not handed to output register");
endmodule

FILE: src/ffha_dp.sv
// Datapath of the heap allocator: walk pointers, sizes, header store access
// and the output register. Depends on ffha_pkg; the store is external RAM.
module ffha_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_operation,
  input  logic [ffha_pkg::REQ_W-1:0]       in_request_size,
  input  logic [ffha_pkg::ADDR_W-1:0]      in_block_address,
  input  ffha_pkg::ffha_cmd_t              cmd,
  output ffha_pkg::ffha_sts_t              sts,
  output logic                             mem_wr_en,
  output logic [ffha_pkg::STORE_AW-1:0]    mem_wr_addr,
  output logic [ffha_pkg::HDR_W-1:0]       mem_wr_data,
  output logic [ffha_pkg::STORE_AW-1:0]    mem_rd_addr,
  input  logic [ffha_pkg::HDR_W-1:0]       mem_rd_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_success,
  output logic [ffha_pkg::ADDR_W-1:0]      out_result_address
);
  import ffha_pkg::*;

  logic [OFS_W-1:0]  p_r, p_nxt;
  logic [OFS_W-1:0]  cur_r, cur_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_success_r, out_success_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic              rd_free;
  logic [SIZE_W-1:0] rd_size;
  logic [OFS_W-1:0]  p_plus_rd, cur_plus_rd, p_plus_size, p_plus_total, p_plus_hdr;
  logic [OFS_W-1:0]  merge_sum;
  logic [SIZE_W-1:0] rest;
  logic [REQ_W:0]    req_total;
  logic [ADDR_W-1:0] free_hdr;

  assign rd_free = mem_rd_data[HDR_W-1];
  assign rd_size = mem_rd_data[SIZE_W-1:0];
  assign p_plus_rd = p_r + {1'b0, rd_size};
  assign cur_plus_rd = cur_r + {1'b0, rd_size};
  assign p_plus_size = p_r + {1'b0, size_r};
  assign p_plus_total = p_r + {1'b0, total_r};
  assign p_plus_hdr = p_r + HEADER_BYTES;
  assign merge_sum = {1'b0, size_r} + {1'b0, rd_size};
  assign rest = size_r - total_r;
  assign req_total = {1'b0, in_request_size} + {1'b0, HEADER_BYTES};
  assign free_hdr = in_block_address - HEADER_BYTES[ADDR_W-1:0];

  always_comb begin
    sts.is_free = (in_operation == OP_FREE);
    sts.too_big = (req_total >= {1'b0, HEAP_BYTES});
    sts.p_past_end = (p_r >= HEAP_BYTES);
    sts.hdr_free = rd_free;
    sts.hdr_size_zero = (rd_size == '0);
    sts.merge_go = (cur_r < HEAP_BYTES) && rd_free && (rd_size != '0);
    sts.fits = (total_r < size_r);
    sts.rest_big = (rest > HEADER_BYTES[SIZE_W-1:0]);
    sts.size_zero = (size_r == '0);
    sts.out_stall = out_valid_r && !out_ready;
  end

  always_comb begin
    p_nxt = p_r;
    cur_nxt = cur_r;
    size_nxt = size_r;
    total_nxt = total_r;
    res_ok_nxt = res_ok_r;
    res_addr_nxt = res_addr_r;
    mem_wr_en = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_addr = '0;
    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_INIT_WR: begin
        mem_wr_en = 1'b1;
        mem_wr_data = {1'b1, HEAP_BYTES[SIZE_W-1:0]};
      end
      DP_LOAD: begin
        total_nxt = req_total[SIZE_W-1:0];
        res_ok_nxt = sts.is_free;
        res_addr_nxt = '0;
        if (sts.is_free) begin
          p_nxt = {{(OFS_W-ADDR_W){1'b0}}, free_hdr};
          mem_rd_addr = free_hdr;
        end else begin
          p_nxt = '0;
        end
      end
      DP_FREE_WR: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = p_r[STORE_AW-1:0];
        mem_wr_data = {1'b1, mem_rd_data[SIZE_W-1:0]};
      end
      DP_SRCH_STEP: begin
        p_nxt = p_plus_rd;
        mem_rd_addr = p_plus_rd[STORE_AW-1:0];
      end
      DP_SRCH_HIT: begin
        size_nxt = rd_size;
        cur_nxt = p_plus_rd;
        mem_rd_addr = p_plus_rd[STORE_AW-1:0];
      end
      DP_MERGE_STEP: begin
        size_nxt = merge_sum[OFS_W-1] ? '1 : merge_sum[SIZE_W-1:0];
        cur_nxt = cur_plus_rd;
        mem_rd_addr = cur_plus_rd[STORE_AW-1:0];
      end
      DP_MERGE_END: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = p_r[STORE_AW-1:0];
        mem_wr_data = {1'b1, size_r};
      end
      DP_TAKE_SPLIT: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = p_r[STORE_AW-1:0];
        mem_wr_data = {1'b0, total_r};
        res_ok_nxt = 1'b1;
        res_addr_nxt = p_plus_hdr[ADDR_W-1:0];
      end
      DP_TAKE_WHOLE: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = p_r[STORE_AW-1:0];
        mem_wr_data = {1'b0, size_r};
        res_ok_nxt = 1'b1;
        res_addr_nxt = p_plus_hdr[ADDR_W-1:0];
      end
      DP_ADV: begin
        p_nxt = p_plus_size;
        mem_rd_addr = p_plus_size[STORE_AW-1:0];
      end
      DP_SPLIT_WR: begin
        mem_wr_en = 1'b1;
        mem_wr_addr = p_plus_total[STORE_AW-1:0];
        mem_wr_data = {1'b1, rest};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_success_nxt = out_success_r;
    out_addr_nxt = out_addr_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_success_nxt = res_ok_r;
      out_addr_nxt = res_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    p_r <= p_nxt;
    cur_r <= cur_nxt;
    size_r <= size_nxt;
    total_r <= total_nxt;
    res_ok_r <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    out_success_r <= out_success_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_success = out_success_r;
  assign out_result_address = out_addr_r;

  a_split_leaves_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_TAKE_SPLIT) |-> (total_r < size_r) && (rest > HEADER_BYTES[SIZE_W-1:0]))
    else $error("split would leave a rest no larger than a header");
endmodule

FILE: src/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over a 64 KiB heap with a 65536-entry header store; top level.
// A free sets the free bit in the block's header; an oversized allocate answers without a walk.
// Other allocates walk the headers, including a final step past the heap end, merge the free
// chunks that follow each free chunk reached, and split off a rest larger than a header.
// One beat is in flight at a time; while a result stalls at the output, the next result waits.
// Reset is synchronous; after reset the initial free chunk is written, then ready rises.
module first_fit_heap_allocator_unit (
  input logic       clk,
  input logic       rst_n,
  ffha_in_if.sink   in_chan,
  ffha_out_if.source out_chan
);
  import ffha_pkg::*;

  ffha_cmd_t             cmd;
  ffha_sts_t             sts;
  logic                  in_ready;
  logic                  mem_wr_en;
  logic [STORE_AW-1:0]   mem_wr_addr;
  logic [HDR_W-1:0]      mem_wr_data;
  logic [STORE_AW-1:0]   mem_rd_addr;
  logic [HDR_W-1:0]      mem_rd_data;

  assign in_chan.ready = in_ready;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_chan.operation),
    .in_request_size    (in_chan.request_size),
    .in_block_address   (in_chan.block_address),
    .cmd                (cmd),
    .sts                (sts),
    .mem_wr_en          (mem_wr_en),
    .mem_wr_addr        (mem_wr_addr),
    .mem_wr_data        (mem_wr_data),
    .mem_rd_addr        (mem_rd_addr),
    .mem_rd_data        (mem_rd_data),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_success        (out_chan.success),
    .out_result_address (out_chan.result_address)
  );

  ffha_ram #(
    .DATA_W (HDR_W),
    .DEPTH  (STORE_DEPTH)
  ) u_hdr_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );
endmodule
